/* design/priority_ready_queue_top_assert.svh */
// ----------------------------------------------------------------------------
// priority ready queue assertion macros
// shared assertion forms, all sampled on the rising edge of clock
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_TOP_ASSERT_SVH
`define PRIORITY_READY_QUEUE_TOP_ASSERT_SVH

// property checked outside of reset
`define PRQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked on every edge, reset included
`define PRQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* design/prq_pkg.sv */
// ----------------------------------------------------------------------------
// prq_pkg
// types, codes and sizes shared by the ready queue cells and top level
// ----------------------------------------------------------------------------
package prq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_W        = 8;
   localparam int PRIO_W      = 6;
   localparam int PRIO_LEVELS = 64;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_INSERT_AFTER  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT_BEFORE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP           = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CHANGE_PRIO   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_REMOVE
   } cell_op_type;

   // one slot of the queue
   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] pri;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      cell_op_type       op;
      logic              front;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] pri;
   } cell_cmd_type;

   localparam entry_type ENTRY_NONE = '{valid: 1'b0, id: '0, pri: '0};

endpackage

/* design/prq_cell.sv */
// ----------------------------------------------------------------------------
// prq_cell
// one slot of the sorted queue; keeps, shifts or takes a new entry
// ----------------------------------------------------------------------------
module prq_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  prq_pkg::cell_cmd_type cmd,
   input  prq_pkg::entry_type   left_entry,
   input  logic                 left_ahead,
   input  prq_pkg::entry_type   right_entry,
   input  logic                 found_in,
   output prq_pkg::entry_type   entry,
   output logic                 ahead,
   output logic                 found_out
);
   import prq_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [ID_W-1:0]   id_ff;
   logic [ID_W-1:0]   id_in;
   logic [PRIO_W-1:0] pri_ff;
   logic [PRIO_W-1:0] pri_in;
   entry_type         next_entry;

   assign entry = '{valid: valid_ff, id: id_ff, pri: pri_ff};

   // entry stays in front of the new item
   assign ahead = valid_ff && (cmd.front ? (pri_ff > cmd.pri) : (pri_ff >= cmd.pri));

   // frontmost match seen at or before this slot
   assign found_out = found_in || (valid_ff && (id_ff == cmd.id));

   always_comb begin
      next_entry = entry;
      case (cmd.op)
         CELL_INSERT: begin
            if (!ahead) begin
               if (left_ahead) begin
                  next_entry = '{valid: 1'b1, id: cmd.id, pri: cmd.pri};
               end else begin
                  next_entry = left_entry;
               end
            end
         end
         CELL_POP: begin
            next_entry = right_entry;
         end
         CELL_REMOVE: begin
            if (found_out) begin
               next_entry = right_entry;
            end
         end
         default: begin
            next_entry = entry;
         end
      endcase
   end

   assign valid_in = next_entry.valid;
   assign id_in    = next_entry.id;
   assign pri_in   = next_entry.pri;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

endmodule

/* design/priority_ready_queue_top.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_top
// scheduler ready queue of task ids kept sorted by priority in a cell chain
// ----------------------------------------------------------------------------
// usage
//   req channel carries one item: action, task id and priority
//   rsp channel returns one item per request: id, status and occupancy
//   csr_write_en loads the id that a pop on an empty queue returns
// timing
//   insert and pop finish in the accept cycle, the result shows in the cycle after
//   change priority makes a remove pass through the chain, then a reinsert
//     pass behind equal priorities; the result is registered in the reinsert pass
//   insert and pop run at one item per cycle while req_stall is low; change
//     priority closes intake during its reinsert pass, set by the single update the cell chain makes per cycle
// reset
//   synchronous, active high; empties the queue and clears idle id to zero
// backpressure
//   one result register sits on rsp; while it holds an item and rsp_stall is
//   high, or during a reinsert pass, req_stall is raised and no new item is taken
// ----------------------------------------------------------------------------
module priority_ready_queue_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [prq_pkg::ACTION_W-1:0]  req_action,
   input  logic [prq_pkg::ID_W-1:0]      req_task_id,
   input  logic [prq_pkg::PRIO_W-1:0]    req_priority_req,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [prq_pkg::ID_W-1:0]      rsp_result_id,
   output logic [prq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [prq_pkg::COUNT_W-1:0]   rsp_occupancy,
   // configuration
   input  logic                          csr_write_en,
   input  logic [prq_pkg::ID_W-1:0]      csr_write_data
);
   import prq_pkg::*;

`include "priority_ready_queue_top_assert.svh"

   typedef enum logic {
      ST_IDLE,
      ST_REINSERT
   } state_type;

   state_type             state_ff;
   state_type             state_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [ID_W-1:0]       idle_id_ff;
   logic [ID_W-1:0]       idle_id_in;
   logic [ID_W-1:0]       hold_id_ff;
   logic [ID_W-1:0]       hold_id_in;
   logic [PRIO_W-1:0]     hold_pri_ff;
   logic [PRIO_W-1:0]     hold_pri_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [ID_W-1:0]       rsp_id_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   rsp_status_in;
   logic [COUNT_W-1:0]    rsp_occ_ff;
   logic [COUNT_W-1:0]    rsp_occ_in;

   logic                  accept;
   logic                  rsp_load;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  id_found;
   logic [PRIO_W-1:0]     pri_sat;
   cell_cmd_type          cmd;

   // chain wiring
   entry_type             cell_entry [QUEUE_DEPTH];
   entry_type             left_entry [QUEUE_DEPTH];
   entry_type             right_entry[QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_ahead;
   logic [QUEUE_DEPTH-1:0] left_ahead;
   logic [QUEUE_DEPTH-1:0] found_in;
   logic [QUEUE_DEPTH-1:0] found_out;
   logic [QUEUE_DEPTH-1:0] valid_vec;

   // intake closes while reinserting or while a result waits on a stalled rsp
   assign req_stall = (state_ff == ST_REINSERT) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign queue_full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign id_found    = found_out[QUEUE_DEPTH-1];

   // priorities past the top level clamp to the top level
   assign pri_sat = (req_priority_req > PRIO_W'(PRIO_LEVELS - 1)) ?
                    PRIO_W'(PRIO_LEVELS - 1) : req_priority_req;

   // ---------------------------------------------------------------------
   // cell chain: slot 0 is the front of the queue
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_entry[i] = ENTRY_NONE;
         assign left_ahead[i] = 1'b1;
         assign found_in[i]   = 1'b0;
      end else begin : g_body
         assign left_entry[i] = cell_entry[i-1];
         assign left_ahead[i] = cell_ahead[i-1];
         assign found_in[i]   = found_out[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry[i] = ENTRY_NONE;
      end else begin : g_inner
         assign right_entry[i] = cell_entry[i+1];
      end

      prq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry[i]),
         .left_ahead  (left_ahead[i]),
         .right_entry (right_entry[i]),
         .found_in    (found_in[i]),
         .entry       (cell_entry[i]),
         .ahead       (cell_ahead[i]),
         .found_out   (found_out[i])
      );

      assign valid_vec[i] = cell_entry[i].valid;
   end

   // ---------------------------------------------------------------------
   // command to the chain and next control state
   // ---------------------------------------------------------------------
   always_comb begin
      cmd           = '{op: CELL_HOLD, front: 1'b0, id: req_task_id, pri: pri_sat};
      state_in      = state_ff;
      count_in      = count_ff;
      hold_id_in    = hold_id_ff;
      hold_pri_in   = hold_pri_ff;
      rsp_load      = 1'b0;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      idle_id_in    = csr_write_en ? csr_write_data : idle_id_ff;

      if (state_ff == ST_REINSERT) begin
         // second pass of change priority: back in behind its equals
         cmd           = '{op: CELL_INSERT, front: 1'b0, id: hold_id_ff, pri: hold_pri_ff};
         count_in      = count_ff + COUNT_W'(1);
         state_in      = ST_IDLE;
         rsp_load      = 1'b1;
         rsp_id_in     = hold_id_ff;
         rsp_status_in = ST_OK;
         rsp_occ_in    = count_ff + COUNT_W'(1);
      end else if (accept) begin
         rsp_id_in     = req_task_id;
         rsp_status_in = ST_OK;
         rsp_occ_in    = count_ff;
         case (req_action)
            ACT_INSERT_AFTER, ACT_INSERT_BEFORE: begin
               rsp_load = 1'b1;
               if (queue_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cmd.op     = CELL_INSERT;
                  cmd.front  = (req_action == ACT_INSERT_BEFORE);
                  count_in   = count_ff + COUNT_W'(1);
                  rsp_occ_in = count_ff + COUNT_W'(1);
               end
            end
            ACT_POP: begin
               rsp_load = 1'b1;
               if (queue_empty) begin
                  rsp_id_in     = idle_id_ff;
                  rsp_status_in = ST_EMPTY;
               end else begin
                  cmd.op     = CELL_POP;
                  rsp_id_in  = cell_entry[0].id;
                  count_in   = count_ff - COUNT_W'(1);
                  rsp_occ_in = count_ff - COUNT_W'(1);
               end
            end
            ACT_CHANGE_PRIO: begin
               // first pass: drop the frontmost entry with this id
               cmd.op = CELL_REMOVE;
               if (id_found) begin
                  count_in    = count_ff - COUNT_W'(1);
                  hold_id_in  = req_task_id;
                  hold_pri_in = pri_sat;
                  state_in    = ST_REINSERT;
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_NOTFOUND;
               end
            end
            default: begin
               rsp_load = 1'b0;
            end
         endcase
      end

      // result register: load wins, otherwise drain when taken
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idle_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idle_id_ff   <= idle_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_id_ff    <= hold_id_in;
      hold_pri_ff   <= hold_pri_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // occupied slots are exactly as many as the fill count
   `PRQ_ASSERT_ALWAYS(a_count_matches_cells, reset || ($countones(valid_vec) == count_ff), "fill count disagrees with valid cells")
   // the reinsert pass always starts with the result register free
   `PRQ_ASSERT(a_reinsert_rsp_free, (state_ff == ST_REINSERT) |-> !rsp_valid_ff, "result register busy at reinsert")
   // a refused insert only ever reports a full queue
   `PRQ_ASSERT(a_full_status_depth, (rsp_valid_ff && (rsp_status_ff == ST_FULL)) |-> (rsp_occ_ff == COUNT_W'(QUEUE_DEPTH)), "full status with room left")
   // a reinsert never runs out of room, the remove pass freed a slot
   `PRQ_ASSERT(a_reinsert_not_full, (state_ff == ST_REINSERT) |-> !queue_full, "reinsert into full queue")

endmodule

/* sim/priority_ready_queue_top_tb.sv */
// ----------------------------------------------------------------------------
// priority_ready_queue_top_tb
// self-checking bench for the scheduler ready queue: a shadow copy of the
// sorted queue predicts every response, random bursts on req and a rotating
// stall pattern on rsp stress the handshakes, idle id is reloaded per phase
// ----------------------------------------------------------------------------
module priority_ready_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 200;
   localparam int PHASE_COUNT  = 6;

   // one request item as it goes onto the req channel
   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     task_id;
      logic [PRIO_W-1:0]   pri;
   } sched_cmd_type;

   // one response item as it should come back on rsp
   typedef struct {
      logic [ID_W-1:0]     result_id;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  occupancy;
   } sched_rsp_type;

   // dut ports; the inputs are all known from time zero
   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action       = ACT_POP;
   logic [ID_W-1:0]     req_task_id      = '0;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [ID_W-1:0]     rsp_result_id;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_occupancy;
   logic                csr_write_en   = 1'b0;
   logic [ID_W-1:0]     csr_write_data = '0;

   // items waiting to be sent, and responses owed by the dut in order
   sched_cmd_type req_backlog [$];
   sched_rsp_type due_results [$];

   // shadow of the ready queue: slot 0 is the front, highest priority
   logic [ID_W-1:0]   ready_ids  [QUEUE_DEPTH];
   logic [PRIO_W-1:0] ready_pris [QUEUE_DEPTH];
   int                ready_count    = 0;
   logic [ID_W-1:0]   idle_id_shadow = '0;

   int fail_count  = 0;
   int cycle_count = 0;

   // sender burst shaping and receiver stall pattern state
   int          burst_left   = 0;
   int          gap_left     = 0;
   logic [31:0] stall_pattern = '0;
   int          pattern_left = 0;

   priority_ready_queue_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_id    (rsp_result_id),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // shadow queue operations
   // ---------------------------------------------------------------------

   // sorted insert; ahead puts the id in front of its equal priorities,
   // otherwise behind them so equals leave in arrival order
   function automatic void place_task(logic [ID_W-1:0] id, logic [PRIO_W-1:0] pri,
                                      bit ahead);
      int pos;
      pos = 0;
      while (pos < ready_count &&
             (ahead ? (ready_pris[pos] > pri) : (ready_pris[pos] >= pri)))
         pos++;
      for (int i = ready_count; i > pos; i--) begin
         ready_ids[i]  = ready_ids[i-1];
         ready_pris[i] = ready_pris[i-1];
      end
      ready_ids[pos]  = id;
      ready_pris[pos] = pri;
      ready_count++;
   endfunction

   // take slot pos out and close the gap behind it
   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < ready_count; i++) begin
         ready_ids[i]  = ready_ids[i+1];
         ready_pris[i] = ready_pris[i+1];
      end
      ready_count--;
   endfunction

   // apply one accepted item to the shadow and record the response it owes
   // a 6 bit priority can never reach past the top level, so no clamping
   function automatic void apply_queue_op(logic [ACTION_W-1:0] action,
                                          logic [ID_W-1:0] id,
                                          logic [PRIO_W-1:0] pri);
      sched_rsp_type owed;
      int            hit;
      owed.result_id = id;
      owed.status    = ST_OK;
      case (action)
         ACT_INSERT_AFTER, ACT_INSERT_BEFORE: begin
            // a full queue refuses the insert and stays as it is
            if (ready_count >= QUEUE_DEPTH)
               owed.status = ST_FULL;
            else
               place_task(id, pri, action == ACT_INSERT_BEFORE);
         end
         ACT_POP: begin
            if (ready_count == 0) begin
               owed.result_id = idle_id_shadow;
               owed.status    = ST_EMPTY;
            end else begin
               owed.result_id = ready_ids[0];
               drop_slot(0);
            end
         end
         default: begin
            // change priority works on the frontmost copy of the id
            hit = -1;
            for (int i = 0; i < ready_count; i++) begin
               if (hit < 0 && ready_ids[i] == id)
                  hit = i;
            end
            if (hit < 0) begin
               owed.status = ST_NOTFOUND;
            end else begin
               drop_slot(hit);
               place_task(id, pri, 1'b0);
            end
         end
      endcase
      owed.occupancy = ready_count[COUNT_W-1:0];
      due_results.push_back(owed);
   endfunction

   // ---------------------------------------------------------------------
   // req driver: sends backlog items in bursts with random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      sched_cmd_type next_cmd;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         // item taken at this edge: predict its response now
         if (req_valid && !req_stall)
            apply_queue_op(req_action, req_task_id, req_priority_req);
         // a stalled item stays on the bus untouched
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || req_backlog.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_cmd = req_backlog.pop_front();
               req_valid        <= 1'b1;
               req_action       <= next_cmd.action;
               req_task_id      <= next_cmd.task_id;
               req_priority_req <= next_cmd.pri;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a quarter of them follow without any gap
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor: checks every taken response, stalls on a rotating pattern
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      sched_rsp_type want;
      if (reset) begin
         rsp_stall    <= 1'b0;
         pattern_left = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (due_results.size() == 0) begin
               $error("unexpected rsp item: result_id %0h status %0d occupancy %0d",
                      rsp_result_id, rsp_status, rsp_occupancy);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_result_id !== want.result_id) begin
                  $error("result_id mismatch: expected %0h, actual %0h",
                         want.result_id, rsp_result_id);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy mismatch: expected %0d, actual %0d",
                         want.occupancy, rsp_occupancy);
                  fail_count++;
               end
            end
         end
         // pick a new stall pattern now and then: none, sparse, half or dense
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern = '0;
               1:       stall_pattern = $urandom & $urandom & $urandom;
               2:       stall_pattern = $urandom;
               default: stall_pattern = $urandom | $urandom;
            endcase
            // one open slot per turn of the pattern bounds every stall
            stall_pattern[0] = 1'b0;
            pattern_left = $urandom_range(32, 200);
         end
         pattern_left--;
         rsp_stall     <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("priority_ready_queue_top verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   function automatic void push_cmd(logic [ACTION_W-1:0] action, logic [ID_W-1:0] id,
                                    logic [PRIO_W-1:0] pri);
      sched_cmd_type cmd;
      cmd.action  = action;
      cmd.task_id = id;
      cmd.pri     = pri;
      req_backlog.push_back(cmd);
   endfunction

   // wait until every item is sent and answered; sampled on the falling
   // edge so the queues and req_valid have all settled
   task automatic wait_for_drain();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0);
      // extra margin only; every owed response has already been taken by now
      repeat (3) @(negedge clock);
   endtask

   // load the id that a pop on an empty queue hands back
   task automatic write_idle_id(logic [ID_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      idle_id_shadow = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // one random phase: a small id pool makes change priority hit often and a
   // small priority set makes equal priorities common; the mix of inserts,
   // pops and changes differs per phase so the queue fills and drains
   task automatic queue_random_phase(int n_items);
      logic [ID_W-1:0]   id_pool  [6];
      logic [PRIO_W-1:0] pri_pool [4];
      int                w_ins;
      int                w_pop;
      int                w_chg;
      int                pick;
      sched_cmd_type     cmd;
      w_ins = $urandom_range(1, 6);
      w_pop = $urandom_range(1, 6);
      w_chg = $urandom_range(0, 4);
      foreach (id_pool[k])
         id_pool[k] = ID_W'($urandom);
      foreach (pri_pool[k])
         pri_pool[k] = PRIO_W'($urandom);
      repeat (n_items) begin
         pick = $urandom_range(0, w_ins + w_pop + w_chg - 1);
         if (pick < w_ins)
            cmd.action = $urandom_range(0, 1) ? ACT_INSERT_BEFORE : ACT_INSERT_AFTER;
         else if (pick < w_ins + w_pop)
            cmd.action = ACT_POP;
         else
            cmd.action = ACT_CHANGE_PRIO;
         // a fifth of the ids come from anywhere, mostly absent ones
         if ($urandom_range(0, 4) != 0)
            cmd.task_id = id_pool[$urandom_range(0, 5)];
         else
            cmd.task_id = ID_W'($urandom);
         if ($urandom_range(0, 2) != 0)
            cmd.pri = pri_pool[$urandom_range(0, 3)];
         else
            cmd.pri = PRIO_W'($urandom);
         req_backlog.push_back(cmd);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_idle_id(8'hC3);

      // directed: empty queue cases first
      push_cmd(ACT_POP,           8'h00, 6'h00);
      push_cmd(ACT_CHANGE_PRIO,   8'hFF, 6'h3F);
      // extremes of id and priority, both insert flavors among equals
      push_cmd(ACT_INSERT_AFTER,  8'h00, 6'h00);
      push_cmd(ACT_INSERT_AFTER,  8'hFF, 6'h3F);
      push_cmd(ACT_INSERT_BEFORE, 8'h55, 6'h3F);
      push_cmd(ACT_INSERT_AFTER,  8'hAA, 6'h00);
      push_cmd(ACT_INSERT_BEFORE, 8'h0F, 6'h00);
      // move to the top level, behind the ones already there
      push_cmd(ACT_CHANGE_PRIO,   8'h00, 6'h3F);
      // absent id
      push_cmd(ACT_CHANGE_PRIO,   8'hAB, 6'h20);
      // duplicate id, then a change that must pick the frontmost copy
      push_cmd(ACT_INSERT_AFTER,  8'hFF, 6'h20);
      push_cmd(ACT_CHANGE_PRIO,   8'hFF, 6'h01);
      // fill to the last slot
      for (int k = 0; k < QUEUE_DEPTH - 6; k++)
         push_cmd(k[0] ? ACT_INSERT_BEFORE : ACT_INSERT_AFTER, ID_W'(8'h10 + k),
                  6'(k * 7));
      // inserts refused while full, a change on a full queue, one pop
      push_cmd(ACT_INSERT_AFTER,  8'hF0, 6'h3F);
      push_cmd(ACT_INSERT_BEFORE, 8'h0F, 6'h00);
      push_cmd(ACT_CHANGE_PRIO,   8'h55, 6'h00);
      push_cmd(ACT_POP,           8'hFF, 6'h3F);
      wait_for_drain();

      // random phases, idle id reloaded between them with both extremes
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 3)
            0:       write_idle_id(8'hFF);
            1:       write_idle_id(8'h00);
            default: write_idle_id(ID_W'($urandom));
         endcase
         queue_random_phase(PHASE_ITEMS);
         wait_for_drain();
      end

      // let any stray response show up before the verdict
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("priority_ready_queue_top verification clean");
      else
         $display("priority_ready_queue_top verification failed");
      $finish;
   end

endmodule

/* priority_ready_queue_top.f */
+incdir+design
design/prq_pkg.sv
design/prq_cell.sv
design/priority_ready_queue_top.sv
sim/priority_ready_queue_top_tb.sv
